[design/perlin_noise_3d_assert.svh]
// Assertion macros used by the checker file pn3d_checker.sv.
`ifndef PERLIN_NOISE_3D_ASSERT_SVH
`define PERLIN_NOISE_3D_ASSERT_SVH

// Condition in this cycle implies consequence in the next one.
`define PN3D_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

// Condition implies consequence in the same cycle.
`define PN3D_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

`endif

[design/pn3d_pkg.sv]
`default_nettype none
package pn3d_pkg;

  localparam int unsigned FracBits    = 16;
  localparam int unsigned OutFracBits = 14;
  localparam int unsigned CoordW      = 24;
  localparam int unsigned NoiseW      = 16;
  localparam int unsigned OffW        = FracBits + 2;  // signed t or t-1
  localparam int unsigned DotW        = OffW + 1;      // sum of two offsets
  localparam int unsigned FadeW       = FracBits + 1;
  localparam int unsigned QW          = FracBits + 4;

  typedef logic [7:0] cell_t;
  typedef logic [FracBits-1:0] frac_t;
  typedef logic signed [OffW-1:0] off_t;
  typedef logic signed [DotW-1:0] dot_t;
  typedef logic [FadeW-1:0] fade_t;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,8'd74,
    8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,
    8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,
    8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
    8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,
    8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
    8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,
    8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,
    8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,
    8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,
    8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,
    8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,
    8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,
    8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,
    8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,
    8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

  function automatic cell_t perm(input cell_t idx);
    return PERM[idx];
  endfunction

  // Gradient select and dot product for one corner.
  function automatic dot_t grad(input logic [3:0] h, input off_t dx, input off_t dy,
                                input off_t dz);
    off_t a;
    off_t b;
    dot_t sa;
    dot_t sb;
    a = h[3] ? dy : dx;
    if (h < 4'd4) begin
      b = dy;
    end else if (h == 4'd12 || h == 4'd14) begin
      b = dx;
    end else begin
      b = dz;
    end
    sa = DotW'(a);
    sb = DotW'(b);
    if (h[0]) sa = -sa;
    if (h[1]) sb = -sb;
    return sa + sb;
  endfunction

endpackage
`default_nettype wire

[design/pn3d_if.sv]
`default_nettype none
interface pn3d_in_if;
  logic                  valid;
  logic                  ready;
  logic [pn3d_pkg::CoordW-1:0] coord_x;
  logic [pn3d_pkg::CoordW-1:0] coord_y;
  logic [pn3d_pkg::CoordW-1:0] coord_z;
  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface pn3d_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pn3d_pkg::NoiseW-1:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface
`default_nettype wire

[design/pn3d_lerp.sv]
`default_nettype none
// Registered lerp: y = a + floor((b - a) * t / 2^F).
module pn3d_lerp (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire pn3d_pkg::dot_t        a_i,
  input  wire pn3d_pkg::dot_t        b_i,
  input  wire pn3d_pkg::fade_t       t_i,
  output      pn3d_pkg::dot_t        y_o
);
  import pn3d_pkg::*;

  logic signed [DotW:0]             diff;
  logic signed [DotW+FadeW+1:0]     prod;
  dot_t                             y_d;
  dot_t                             y_q;

  always_comb begin
    diff = (DotW+1)'(b_i) - (DotW+1)'(a_i);
    prod = (DotW+FadeW+2)'(diff) * $signed({1'b0, t_i});
    // arithmetic shift floors toward minus infinity
    y_d  = a_i + DotW'(prod >>> FracBits);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) y_q <= y_d;
  end

  assign y_o = y_q;
endmodule
`default_nettype wire

[design/perlin_noise_3d.sv]
`default_nettype none
// Throughput: one point per cycle; the seven-stage pipeline advances whenever
// the output register is empty or its result is taken.
// Reset: asynchronous active low, clears all stage valid bits; no result is
// pending after reset.
module perlin_noise_3d (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  pn3d_in_if.sink   in_i,
  pn3d_out_if.source out_o
);
  import pn3d_pkg::*;

  localparam int unsigned NStg = 7;
  localparam logic [FracBits+1:0] One = (FracBits+2)'(1) << FracBits;

  logic            en;
  logic [NStg-1:0] vld_q;

  // stage 1: split, first hash, t^2
  cell_t               iy1_q, iz1_q, pa1_q, pb1_q;
  frac_t               fx1_q, fy1_q, fz1_q;
  logic [2*FracBits-1:0] tt1_q [3];
  // stage 2: second hash, q and t2
  cell_t               haa2_q, hab2_q, hba2_q, hbb2_q;
  frac_t               fx2_q, fy2_q, fz2_q;
  logic [QW-1:0]       q2_q [3];
  frac_t               t22_q [3];
  // stage 3: corner codes, t3
  logic [3:0]          h3_q [8];
  frac_t               fx3_q, fy3_q, fz3_q;
  logic [QW-1:0]       q3_q [3];
  frac_t               t33_q [3];
  // stage 4: dots, fade
  dot_t                dot4_q [8];
  fade_t               u4_q, v4_q, w4_q;
  fade_t               v5_q, w5_q, w6_q;
  dot_t                l5 [4];
  dot_t                l6 [2];

  assign en       = !vld_q[NStg-1] || out_o.ready;
  assign in_i.ready = en;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], in_i.valid};
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (en) begin
      pa1_q <= perm(in_i.coord_x[FracBits +: 8]);
      pb1_q <= perm(in_i.coord_x[FracBits +: 8] + 8'd1);
      iy1_q <= in_i.coord_y[FracBits +: 8];
      iz1_q <= in_i.coord_z[FracBits +: 8];
      fx1_q <= in_i.coord_x[FracBits-1:0];
      fy1_q <= in_i.coord_y[FracBits-1:0];
      fz1_q <= in_i.coord_z[FracBits-1:0];
      tt1_q[0] <= in_i.coord_x[FracBits-1:0] * in_i.coord_x[FracBits-1:0];
      tt1_q[1] <= in_i.coord_y[FracBits-1:0] * in_i.coord_y[FracBits-1:0];
      tt1_q[2] <= in_i.coord_z[FracBits-1:0] * in_i.coord_z[FracBits-1:0];
    end
  end

  // stage 2
  cell_t ha, hb;
  frac_t t1 [3];
  logic [QW-1:0] q_d [3];
  always_comb begin
    ha = pa1_q + iy1_q;
    hb = pb1_q + iy1_q;
    t1[0] = fx1_q;
    t1[1] = fy1_q;
    t1[2] = fz1_q;
    for (int i = 0; i < 3; i++) begin
      // q = 10 - 15t + 6t^2, exact terms then truncated t^2 part
      q_d[i] = QW'(10) * QW'(One) - QW'(15) * QW'(t1[i])
             + QW'((({4'd0, tt1_q[i]} * 3'd6) >> FracBits));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      haa2_q <= perm(ha) + iz1_q;
      hab2_q <= perm(ha + 8'd1) + iz1_q;
      hba2_q <= perm(hb) + iz1_q;
      hbb2_q <= perm(hb + 8'd1) + iz1_q;
      fx2_q <= fx1_q;
      fy2_q <= fy1_q;
      fz2_q <= fz1_q;
      for (int i = 0; i < 3; i++) begin
        q2_q[i]  <= q_d[i];
        t22_q[i] <= tt1_q[i][2*FracBits-1:FracBits];
      end
    end
  end

  // stage 3
  frac_t t2v [3];
  logic [2*FracBits-1:0] t3p [3];
  always_comb begin
    t2v[0] = fx2_q;
    t2v[1] = fy2_q;
    t2v[2] = fz2_q;
    for (int i = 0; i < 3; i++) begin
      t3p[i] = t22_q[i] * t2v[i];
    end
  end

  // corner codes keep the low four bits of the table entry
  always_ff @(posedge clk_i) begin
    if (en) begin
      h3_q[0] <= 4'(perm(haa2_q));
      h3_q[1] <= 4'(perm(hba2_q));
      h3_q[2] <= 4'(perm(hab2_q));
      h3_q[3] <= 4'(perm(hbb2_q));
      h3_q[4] <= 4'(perm(haa2_q + 8'd1));
      h3_q[5] <= 4'(perm(hba2_q + 8'd1));
      h3_q[6] <= 4'(perm(hab2_q + 8'd1));
      h3_q[7] <= 4'(perm(hbb2_q + 8'd1));
      fx3_q <= fx2_q;
      fy3_q <= fy2_q;
      fz3_q <= fz2_q;
      for (int i = 0; i < 3; i++) begin
        q3_q[i]  <= q2_q[i];
        t33_q[i] <= t3p[i][2*FracBits-1:FracBits];
      end
    end
  end

  // stage 4: corner offsets, gradient dots, fade
  off_t x0, y0, z0, x1, y1, z1;
  logic [FracBits+QW-1:0] fp [3];
  always_comb begin
    x0 = OffW'(fx3_q);
    y0 = OffW'(fy3_q);
    z0 = OffW'(fz3_q);
    x1 = x0 - OffW'(One);
    y1 = y0 - OffW'(One);
    z1 = z0 - OffW'(One);
    for (int i = 0; i < 3; i++) begin
      fp[i] = t33_q[i] * q3_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dot4_q[0] <= grad(h3_q[0], x0, y0, z0);
      dot4_q[1] <= grad(h3_q[1], x1, y0, z0);
      dot4_q[2] <= grad(h3_q[2], x0, y1, z0);
      dot4_q[3] <= grad(h3_q[3], x1, y1, z0);
      dot4_q[4] <= grad(h3_q[4], x0, y0, z1);
      dot4_q[5] <= grad(h3_q[5], x1, y0, z1);
      dot4_q[6] <= grad(h3_q[6], x0, y1, z1);
      dot4_q[7] <= grad(h3_q[7], x1, y1, z1);
      u4_q <= FadeW'(fp[0] >> FracBits);
      v4_q <= FadeW'(fp[1] >> FracBits);
      w4_q <= FadeW'(fp[2] >> FracBits);
    end
  end

  // stage 5: blend along x
  for (genvar g = 0; g < 4; g++) begin : g_lx
    pn3d_lerp u_lerp (
      .clk_i (clk_i), .en_i (en),
      .a_i (dot4_q[2*g]), .b_i (dot4_q[2*g+1]), .t_i (u4_q), .y_o (l5[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v5_q <= v4_q;
      w5_q <= w4_q;
      w6_q <= w5_q;
    end
  end

  // stage 6: blend along y
  for (genvar g = 0; g < 2; g++) begin : g_ly
    pn3d_lerp u_lerp (
      .clk_i (clk_i), .en_i (en),
      .a_i (l5[2*g]), .b_i (l5[2*g+1]), .t_i (v5_q), .y_o (l6[g])
    );
  end

  // stage 7: blend along z, then round and saturate behind the stage 7 register
  logic signed [NoiseW-1:0] out_d;
  localparam int unsigned Dn = FracBits - OutFracBits;

  dot_t res;
  logic signed [DotW:0] tmp;
  logic signed [DotW:0] shf;
  pn3d_lerp u_lz (
    .clk_i (clk_i), .en_i (en),
    .a_i (l6[0]), .b_i (l6[1]), .t_i (w6_q), .y_o (res)
  );

  // res is stage 7; rounding happens when the result sits in the stage 7 register
  always_comb begin
    tmp = (DotW+1)'(res) + (DotW+1)'(1 << (Dn - 1));
    shf = tmp >>> Dn;
  end

  always_comb begin
    if (shf > (DotW+1)'(32767)) begin
      out_d = 16'sh7FFF;
    end else if (shf < -(DotW+1)'(32768)) begin
      out_d = 16'sh8000;
    end else begin
      out_d = NoiseW'(shf);
    end
  end

  assign out_o.valid       = vld_q[NStg-1];
  assign out_o.noise_value = out_d;
endmodule
`default_nettype wire

[design/pn3d_checker.sv]
`default_nettype none
`include "perlin_noise_3d_assert.svh"
module pn3d_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic [15:0] out_noise_i
);
  // stalled result stays offered
  `PN3D_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")
  // stalled result keeps its value
  `PN3D_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i,
                    $stable(out_noise_i), "result changed under stall")
  // pipeline freezes while the output is blocked
  `PN3D_ASSERT_NOW(a_backpressure, out_valid_i && !out_ready_i, !in_ready_i,
                   "input taken while output blocked")
  // with nothing pending at the output, the pipeline always accepts
  `PN3D_ASSERT_NOW(a_free_flow, !out_valid_i, in_ready_i, "stall without blocked result")
  // an offered input always sees a known ready
  `PN3D_ASSERT_NOW(a_in_known, in_valid_i, !$isunknown(in_ready_i), "unknown ready")
endmodule

bind perlin_noise_3d pn3d_checker u_pn3d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_noise_i (out_o.noise_value)
);
`default_nettype wire
